// ===== src/capture_tachometer_rpm_assert.svh =====
// Assertion macros shared by the tachometer RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CAPTURE_TACHOMETER_RPM_ASSERT_SVH
`define CAPTURE_TACHOMETER_RPM_ASSERT_SVH

// checked out of reset only
`define CTACH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("capture_tachometer_rpm: assertion failed");

// checked at every edge, reset included
`define CTACH_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("capture_tachometer_rpm: reset assertion failed");

`endif

// ===== src/ctach_pkg.sv =====
// Types and constants of the fan tachometer.
// No dependencies.
package ctach_pkg;

    localparam int CAPV_W    = 16;
    localparam int UPT_W     = 8;
    localparam int SPEED_W   = 16;
    localparam int RPM_NUM_W = 26;
    localparam int DIV_STEPS = RPM_NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int SAT_PERIOD = 915;

    localparam logic [RPM_NUM_W-1:0] RPM_NUM   = 26'd60_000_000;
    localparam logic [SPEED_W-1:0]   SPEED_MAX = 16'hFFFF;
    localparam logic [UPT_W-1:0]     UPT_RESET = 8'd4;

    localparam logic FUNC_OVF  = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul;
        logic chk;
        logic div_step;
        logic num_bit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic meas;
        logic skip_div;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== src/ctach_evt_if.sv =====
// Event channel: overflow ticks and edge captures.
// Depends on ctach_pkg.
interface ctach_evt_if import ctach_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CAPV_W-1:0] capture_value;

    modport source (output valid, output func, output capture_value, input ready);
    modport sink   (input valid, input func, input capture_value, output ready);
endinterface

// ===== src/ctach_rpm_if.sv =====
// Result channel: speed in RPM and range flag.
// Depends on ctach_pkg.
interface ctach_rpm_if import ctach_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_rpm;
    logic               range_flag;

    modport source (output valid, output speed_rpm, output range_flag, input ready);
    modport sink   (input valid, input speed_rpm, input range_flag, output ready);
endinterface

// ===== src/ctach_cfg_if.sv =====
// Configuration write channel for us_per_tick.
// Depends on ctach_pkg.
interface ctach_cfg_if import ctach_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [UPT_W-1:0] us_per_tick;

    modport source (output valid, output us_per_tick, input ready);
    modport sink   (input valid, input us_per_tick, output ready);
endinterface

// ===== src/ctach_ctrl.sv =====
// Sequencer of the tachometer: accept, multiply, check, divide, output.
// Depends on ctach_pkg and capture_tachometer_rpm_assert.svh.
`include "capture_tachometer_rpm_assert.svh"

module ctach_ctrl import ctach_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_evt_valid,
    output logic    o_evt_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] bit_idx;

    assign bit_idx = STEP_W'(RPM_NUM_W - 1) - r_step;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_evt_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_evt_ready = 1'b1;
                if (i_evt_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.meas) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_step    = '0;
                n_state   = i_sts.skip_div ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.num_bit  = RPM_NUM[bit_idx];
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `CTACH_ASSERT(ctrl_div_bound, (r_state == ST_DIV) |-> (r_step <= STEP_W'(DIV_STEPS - 1)))
    `CTACH_ASSERT(ctrl_mul_from_idle, (r_state == ST_MUL) |-> ($past(r_state) == ST_IDLE))
    `CTACH_ASSERT_RST(ctrl_rst_idle, !i_rst_n |=> (r_state == ST_IDLE))

endmodule

// ===== src/ctach_dp.sv =====
// Datapath of the tachometer: capture state, period, bit-serial divider,
// output register. Depends on ctach_pkg and capture_tachometer_rpm_assert.svh.
`include "capture_tachometer_rpm_assert.svh"

module ctach_dp import ctach_pkg::*; #(
    parameter int COUNT_WIDTH  = 8,
    parameter int CAPTURE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [UPT_W-1:0]   i_cfg_data,
    input  logic               i_func,
    input  logic [CAPV_W-1:0]  i_capture_value,
    input  logic               i_out_ready,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic [SPEED_W-1:0] o_speed_rpm,
    output logic               o_range_flag
);

    localparam int CAP_W  = (CAPTURE_BITS < CAPV_W) ? CAPTURE_BITS : CAPV_W;
    localparam int TICK_W = COUNT_WIDTH + CAPTURE_BITS;
    localparam int PROD_W = TICK_W + UPT_W;
    localparam int CMP_W  = (PROD_W > RPM_NUM_W) ? PROD_W : RPM_NUM_W;

    logic [UPT_W-1:0]       r_upt, n_upt;
    logic [CAP_W-1:0]       r_last, n_last;
    logic                   r_await, n_await;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_out_valid, n_out_valid;

    logic [TICK_W-1:0]      r_ticks, n_ticks;
    logic                   r_flag, n_flag;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [RPM_NUM_W-1:0]   r_rem, n_rem;
    logic [RPM_NUM_W-1:0]   r_div, n_div;
    logic [SPEED_W-1:0]     r_quot, n_quot;
    logic [SPEED_W-1:0]     r_spd, n_spd;
    logic                   r_oflag, n_oflag;

    logic [CAP_W-1:0]       cap_lo;
    logic                   wrap;
    logic [COUNT_WIDTH-1:0] cnt_eff;
    logic [TICK_W-1:0]      ticks;
    logic                   cnt_full;
    logic                   sat;
    logic                   big;
    logic [RPM_NUM_W:0]     rem_sh;
    logic [RPM_NUM_W:0]     rem_sub;
    logic                   ge;

    assign cap_lo   = i_capture_value[CAP_W-1:0];
    assign wrap     = (r_count == '0) && (cap_lo < r_last);
    assign cnt_eff  = wrap ? COUNT_WIDTH'(1) : r_count;
    assign ticks    = {cnt_eff, CAPTURE_BITS'(cap_lo)} - TICK_W'(r_last);
    assign cnt_full = &r_count;

    // period of zero or too short for 16 bits of RPM
    assign sat = CMP_W'(r_prod) <= CMP_W'(SAT_PERIOD);
    assign big = CMP_W'(r_prod) > CMP_W'(RPM_NUM);

    assign rem_sh  = {r_rem, i_cmd.num_bit};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign ge      = rem_sh >= {1'b0, r_div};

    assign o_sts.meas     = (i_func == FUNC_EDGE) && !r_await;
    assign o_sts.skip_div = sat || big;
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    always_comb begin
        n_upt       = r_upt;
        n_last      = r_last;
        n_await     = r_await;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_ticks     = r_ticks;
        n_flag      = r_flag;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quot      = r_quot;
        n_spd       = r_spd;
        n_oflag     = r_oflag;

        if (i_cfg_valid) begin
            n_upt = i_cfg_data;
        end

        if (i_cmd.accept) begin
            if (i_func == FUNC_EDGE) begin
                n_last  = cap_lo;
                n_count = '0;
                n_await = 1'b0;
                n_ticks = ticks;
                n_flag  = cnt_full;
            end else if (!r_await && !cnt_full) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end

        if (i_cmd.mul) begin
            n_prod = PROD_W'(r_ticks) * PROD_W'(r_upt);
        end

        if (i_cmd.chk) begin
            n_rem  = '0;
            n_div  = RPM_NUM_W'(r_prod);
            n_quot = sat ? SPEED_MAX : '0;
        end

        if (i_cmd.div_step) begin
            n_rem  = ge ? RPM_NUM_W'(rem_sub) : RPM_NUM_W'(rem_sh);
            n_quot = {r_quot[SPEED_W-2:0], ge};
        end

        if (i_cmd.load_out) begin
            n_spd       = r_quot;
            n_oflag     = r_flag;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upt       <= UPT_RESET;
            r_last      <= '0;
            r_await     <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upt       <= n_upt;
            r_last      <= n_last;
            r_await     <= n_await;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ticks <= n_ticks;
        r_flag  <= n_flag;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_quot  <= n_quot;
        r_spd   <= n_spd;
        r_oflag <= n_oflag;
    end

    assign o_out_valid  = r_out_valid;
    assign o_speed_rpm  = r_spd;
    assign o_range_flag = r_oflag;

    `CTACH_ASSERT(dp_await_no_count, r_await |-> (r_count == '0))
    `CTACH_ASSERT(dp_load_sets_valid, i_cmd.load_out |=> r_out_valid)

endmodule

// ===== src/capture_tachometer_rpm.sv =====
// Fan tachometer: edge-to-edge period measurement converted to RPM.
// Uses the event, result and configuration channels of i_evt, o_rpm, i_cfg.
// Timer overflow words (func 0) only advance the overflow count; it counts
// from the first edge on and holds at its maximum. The first edge word just
// stores its capture; each later edge word gives one result word:
// 60,000,000 / (ticks * us_per_tick), saturated to 65535, with range_flag set
// when the overflow count had saturated.
// Overflow words are taken in the idle state. An edge word goes to its result by
// accept, multiply, check, 26 steps of the restoring divider (one quotient
// bit per cycle), load of the output register. Saturated periods and periods
// above 60,000,000 us skip the divider.
// After reset us_per_tick is 4 and the block waits for a first edge.
// The configuration channel is always ready; write it only while idle.
// A result waits in the output register while the receiver stalls; events
// keep being taken meanwhile, and a further edge result parks in the output
// step with the event ready low until that register frees up.
// Depends on ctach_pkg, the channel interfaces, ctach_ctrl and ctach_dp.
module capture_tachometer_rpm import ctach_pkg::*; #(
    parameter int COUNT_WIDTH  = 8,
    parameter int CAPTURE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctach_evt_if.sink     i_evt,
    ctach_rpm_if.source   o_rpm,
    ctach_cfg_if.sink     i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    ctach_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (i_evt.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ctach_dp #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.us_per_tick),
        .i_func          (i_evt.func),
        .i_capture_value (i_evt.capture_value),
        .i_out_ready     (o_rpm.ready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_rpm.valid),
        .o_speed_rpm     (o_rpm.speed_rpm),
        .o_range_flag    (o_rpm.range_flag)
    );

endmodule

// ===== dv/capture_tachometer_rpm_test.sv =====
`timescale 1ns / 1ps
// Testbench for capture_tachometer_rpm: directed table, then random event streams.
// Results are checked against an in-bench RPM predictor, with random stalls on both sides.
// Depends on ctach_pkg, the ctach_*_if interfaces and the tachometer RTL.
module capture_tachometer_rpm_test;
    import ctach_pkg::*;

    localparam int              RESET_CYCLES   = 12;
    localparam int              SETTLE_CYCLES  = 40;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              RAND_ITEMS     = 920;
    localparam int              OVF_W          = 8;
    localparam logic [OVF_W-1:0] OVF_MAX       = '1;
    localparam longint unsigned CAP_SPAN       = 64'd65536;

    typedef enum logic [0:0] {ROW_EVT, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_rpm;
        logic               range_flag;
    } t_rpm_word;

    typedef struct packed {
        t_row_kind         kind;
        logic              func;
        logic [CAPV_W-1:0] data;
        logic [9:0]        reps;
        logic              known;
        t_rpm_word         word;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    // known rows carry the result typed in by hand
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_EVT, FUNC_OVF,  16'h0000, 10'd2,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h1234, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h1234, 10'd1,   1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_EVT, FUNC_OVF,  16'hFFFF, 10'd300, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h1234, 10'd1,   1'b1, '{16'h0000, 1'b1}},
        '{ROW_EVT, FUNC_EDGE, 16'hFFFF, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0000, 10'd1,   1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_EVT, FUNC_OVF,  16'h0000, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0000, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_CFG, FUNC_OVF,  16'h00FF, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0001, 10'd1,   1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_EVT, FUNC_OVF,  16'h5A5A, 10'd254, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0001, 10'd1,   1'b1, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_OVF,  16'hA5A5, 10'd255, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0001, 10'd1,   1'b1, '{16'h0000, 1'b1}},
        '{ROW_CFG, FUNC_OVF,  16'h0001, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h00FF, 10'd1,   1'b1, '{16'hFFFF, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h0FFF, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_OVF,  16'h0000, 10'd3,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h8000, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'hAAAA, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_EVT, FUNC_EDGE, 16'h5555, 10'd1,   1'b0, '{16'h0000, 1'b0}},
        '{ROW_CFG, FUNC_OVF,  16'h0004, 10'd1,   1'b0, '{16'h0000, 1'b0}}
    };

    logic clk;
    logic rst_n;

    ctach_evt_if evt_if ();
    ctach_rpm_if rpm_if ();
    ctach_cfg_if cfg_if ();

    capture_tachometer_rpm dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_if),
        .o_rpm   (rpm_if),
        .i_cfg   (cfg_if)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // predictor state
    logic [UPT_W-1:0]  model_upt     = UPT_RESET;
    logic [CAPV_W-1:0] model_last    = '0;
    bit                model_waiting = 1'b1;
    logic [OVF_W-1:0]  model_ovf     = '0;

    t_rpm_word expected_rpm_q [$];
    t_rpm_word got_word;
    t_rpm_word exp_word;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        steady_src  = 1'b0;
    bit        steady_snk  = 1'b0;

    function automatic bit predict_rpm(input logic f, input logic [CAPV_W-1:0] c,
                                       output t_rpm_word w);
        longint unsigned ticks;
        longint unsigned period_us;
        longint unsigned quo;
        w = '0;
        if (f == FUNC_OVF) begin
            if (!model_waiting && model_ovf != OVF_MAX)
                model_ovf++;
            return 1'b0;
        end
        if (model_waiting) begin
            model_waiting = 1'b0;
            model_last    = c;
            model_ovf     = '0;
            return 1'b0;
        end
        ticks = longint'(model_ovf) * CAP_SPAN + longint'(c);
        if (ticks < longint'(model_last))
            ticks += CAP_SPAN;
        ticks -= longint'(model_last);
        period_us = ticks * longint'(model_upt);
        quo = (period_us == 0) ? longint'(SPEED_MAX) : longint'(RPM_NUM) / period_us;
        w.speed_rpm  = (quo > longint'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];
        w.range_flag = (model_ovf == OVF_MAX);
        model_last = c;
        model_ovf  = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_src)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_event(input logic f, input logic [CAPV_W-1:0] c,
                              input bit known, input t_rpm_word known_w);
        int        gap;
        t_rpm_word w;
        gap = pick_gap();
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_if.valid         <= 1'b1;
        evt_if.func          <= f;
        evt_if.capture_value <= c;
        do @(posedge clk); while (!evt_if.ready);
        if (predict_rpm(f, c, w))
            expected_rpm_q.push_back(known ? known_w : w);
    endtask

    task automatic drain_results();
        evt_if.valid <= 1'b0;
        while (expected_rpm_q.size() != 0)
            @(posedge clk);
        // first edge and overflow words leave nothing to wait on
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_upt(input logic [UPT_W-1:0] v);
        drain_results();
        cfg_if.valid       <= 1'b1;
        cfg_if.us_per_tick <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        model_upt = v;
    endtask

    always @(posedge clk) begin
        if (rst_n && rpm_if.valid && rpm_if.ready) begin
            got_word = '{rpm_if.speed_rpm, rpm_if.range_flag};
            if (expected_rpm_q.size() == 0) begin
                $error("unexpected result word: speed_rpm %0d range_flag %0d",
                       got_word.speed_rpm, got_word.range_flag);
                mismatches++;
            end else begin
                exp_word = expected_rpm_q.pop_front();
                if (got_word.speed_rpm !== exp_word.speed_rpm) begin
                    $error("speed_rpm: expected %0d, got %0d",
                           exp_word.speed_rpm, got_word.speed_rpm);
                    mismatches++;
                end
                if (got_word.range_flag !== exp_word.range_flag) begin
                    $error("range_flag: expected %0d, got %0d",
                           exp_word.range_flag, got_word.range_flag);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (evt_if.valid && evt_if.ready) || (rpm_if.valid && rpm_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result receiver: random stalls, with occasional always-ready stretches
    initial begin
        int n;
        rpm_if.ready <= 1'b0;
        repeat (RESET_CYCLES + 1) @(posedge clk);
        forever begin
            if (steady_snk) begin
                rpm_if.ready <= 1'b1;
                repeat ($urandom_range(20, 100)) @(posedge clk);
            end else begin
                n = $urandom_range(0, 99);
                n = (n < 50) ? $urandom_range(1, 3) :
                    (n < 90) ? $urandom_range(4, 10) : $urandom_range(20, 80);
                rpm_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
                rpm_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial begin
        int                r;
        int                k;
        int                n_ovf;
        int                phase_end;
        int                rand_items;
        logic [CAPV_W-1:0] cap;
        logic [UPT_W-1:0]  upt;
        rst_n                <= 1'b0;
        evt_if.valid         <= 1'b0;
        evt_if.func          <= FUNC_OVF;
        evt_if.capture_value <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.us_per_tick   <= UPT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_upt(dir_rows[i].data[UPT_W-1:0]);
            else
                repeat (dir_rows[i].reps)
                    send_event(dir_rows[i].func, dir_rows[i].data,
                               dir_rows[i].known, dir_rows[i].word);
        end

        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            phase_end  = rand_items + $urandom_range(150, 350);
            steady_src = ($urandom_range(0, 3) == 0);
            steady_snk = ($urandom_range(0, 3) == 0);
            while (rand_items < phase_end && rand_items < RAND_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 90) begin
                    // one revolution: overflow ticks, then the edge
                    k = $urandom_range(0, 99);
                    n_ovf = (k < 50) ? 0 :
                            (k < 80) ? $urandom_range(1, 3) :
                            (k < 98) ? $urandom_range(4, 30) : $urandom_range(250, 300);
                    repeat (n_ovf) begin
                        send_event(FUNC_OVF, CAPV_W'($urandom), 1'b0, '0);
                        rand_items++;
                    end
                    k = $urandom_range(0, 99);
                    cap = (k < 70) ? CAPV_W'($urandom) :
                          (k < 85) ? model_last + CAPV_W'($urandom_range(0, 40)) :
                                     model_last - CAPV_W'($urandom_range(0, 3));
                    send_event(FUNC_EDGE, cap, 1'b0, '0);
                end else begin
                    send_event(logic'($urandom_range(0, 1)), CAPV_W'($urandom), 1'b0, '0);
                end
                rand_items++;
            end
            k = $urandom_range(0, 3);
            upt = (k == 0) ? UPT_W'(1) : (k == 1) ? UPT_W'(255) : UPT_W'($urandom_range(1, 255));
            write_upt(upt);
        end

        drain_results();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
